### design/rti_pkg.sv
// rti_pkg: shared types and constants for the ray/triangle intersection pipeline.
// Used by rti_geom, rti_range, rti_div and ray_triangle_intersect.
package rti_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_VERTEX_A = 2'd0,
        REG_VERTEX_B = 2'd1,
        REG_VERTEX_C = 2'd2
    } reg_index_t;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 48;
    localparam int T_W         = 32;   // Q16.16 interval bounds and distance
    localparam int T_FRAC      = 16;
    localparam int QUOT_BITS   = 32;   // quotient bits produced by the divider
    localparam int DIV_BPS     = 2;    // quotient bits per divider stage

    // Control that travels with each word between pipeline sections
    typedef struct packed {
        logic valid;
        logic keep;    // all hit tests passed
        logic neg;     // t is negative
    } item_ctl_t;

endpackage

### design/rti_geom.sv
// rti_geom: five stage front end. Edge vectors, 2x2 minors, Cramer products,
// determinant and numerators, sign normalization. Uses rti_pkg.
module rti_geom #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [3*COORD_WIDTH-1:0]     vert_a,
    input  logic [3*COORD_WIDTH-1:0]     vert_b,
    input  logic [3*COORD_WIDTH-1:0]     vert_c,
    input  logic [3*COORD_WIDTH-1:0]     org,
    input  logic [3*COORD_WIDTH-1:0]     dir,
    input  logic signed [rti_pkg::T_W-1:0] t_min,
    input  logic signed [rti_pkg::T_W-1:0] t_max,
    output logic                         out_valid,
    output logic                         out_bad,
    output logic signed [3*COORD_WIDTH+5:0]  det_o,
    output logic signed [3*COORD_WIDTH+21:0] ts_o,
    output logic signed [3*COORD_WIDTH+5:0]  gn_o,
    output logic signed [3*COORD_WIDTH+5:0]  bn_o,
    output logic signed [rti_pkg::T_W-1:0] tmin_o,
    output logic signed [rti_pkg::T_W-1:0] tmax_o
);
    import rti_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;          // coordinate difference
    localparam int MW = 2 * DW + 1;     // 2x2 minor
    localparam int PW = DW + MW;        // Cramer product
    localparam int SW = PW + 2;         // sum of three products
    localparam int TW = SW + T_FRAC;    // t numerator scaled to Q16.16

    // ---- stage 1: edge and offset vectors
    logic signed [DW-1:0] ab_reg [3], ac_reg [3], dv_reg [3], ao_reg [3];
    logic signed [DW-1:0] ab_next [3], ac_next [3], dv_next [3], ao_next [3];
    logic signed [T_W-1:0] tmin1_reg, tmax1_reg;
    logic degen_next, degen1_reg, v1_reg;

    always_comb begin
        for (int ax = 0; ax < 3; ax++) begin
            ab_next[ax] = $signed(vert_a[ax*W +: W]) - $signed(vert_b[ax*W +: W]);
            ac_next[ax] = $signed(vert_a[ax*W +: W]) - $signed(vert_c[ax*W +: W]);
            dv_next[ax] = $signed(dir[ax*W +: W]);
            ao_next[ax] = $signed(vert_a[ax*W +: W]) - $signed(org[ax*W +: W]);
        end
        // two equal vertices never hit
        degen_next = (vert_a == vert_b) || (vert_a == vert_c) || (vert_b == vert_c);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ab_reg     <= ab_next;
            ac_reg     <= ac_next;
            dv_reg     <= dv_next;
            ao_reg     <= ao_next;
            tmin1_reg  <= t_min;
            tmax1_reg  <= t_max;
            degen1_reg <= degen_next;
        end
    end

    // ---- stage 2: 2x2 minors
    // a,b,c = A-B; d,e,f = A-C; g,h,i = dir; j,k,l = A-O
    logic signed [MW-1:0] eihf_next, gfdi_next, dheg_next, akjb_next, jcal_next, blkc_next;
    logic signed [MW-1:0] eihf_reg, gfdi_reg, dheg_reg, akjb_reg, jcal_reg, blkc_reg;
    logic signed [DW-1:0] ab2_reg [3], ac2_reg [3], dv2_reg [3], ao2_reg [3];
    logic signed [T_W-1:0] tmin2_reg, tmax2_reg;
    logic degen2_reg, v2_reg;

    always_comb begin
        eihf_next = ac_reg[1] * dv_reg[2] - dv_reg[1] * ac_reg[2];
        gfdi_next = dv_reg[0] * ac_reg[2] - ac_reg[0] * dv_reg[2];
        dheg_next = ac_reg[0] * dv_reg[1] - ac_reg[1] * dv_reg[0];
        akjb_next = ab_reg[0] * ao_reg[1] - ao_reg[0] * ab_reg[1];
        jcal_next = ao_reg[0] * ab_reg[2] - ab_reg[0] * ao_reg[2];
        blkc_next = ab_reg[1] * ao_reg[2] - ao_reg[1] * ab_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            eihf_reg   <= eihf_next;
            gfdi_reg   <= gfdi_next;
            dheg_reg   <= dheg_next;
            akjb_reg   <= akjb_next;
            jcal_reg   <= jcal_next;
            blkc_reg   <= blkc_next;
            ab2_reg    <= ab_reg;
            ac2_reg    <= ac_reg;
            dv2_reg    <= dv_reg;
            ao2_reg    <= ao_reg;
            tmin2_reg  <= tmin1_reg;
            tmax2_reg  <= tmax1_reg;
            degen2_reg <= degen1_reg;
        end
    end

    // ---- stage 3: twelve Cramer products
    logic signed [PW-1:0] prod_next [12];
    logic signed [PW-1:0] prod_reg [12];
    logic signed [T_W-1:0] tmin3_reg, tmax3_reg;
    logic degen3_reg, v3_reg;

    always_comb begin
        // determinant
        prod_next[0]  = ab2_reg[0] * eihf_reg;
        prod_next[1]  = ab2_reg[1] * gfdi_reg;
        prod_next[2]  = ab2_reg[2] * dheg_reg;
        // t numerator (negated later)
        prod_next[3]  = ac2_reg[2] * akjb_reg;
        prod_next[4]  = ac2_reg[1] * jcal_reg;
        prod_next[5]  = ac2_reg[0] * blkc_reg;
        // gamma numerator
        prod_next[6]  = dv2_reg[2] * akjb_reg;
        prod_next[7]  = dv2_reg[1] * jcal_reg;
        prod_next[8]  = dv2_reg[0] * blkc_reg;
        // beta numerator
        prod_next[9]  = ao2_reg[0] * eihf_reg;
        prod_next[10] = ao2_reg[1] * gfdi_reg;
        prod_next[11] = ao2_reg[2] * dheg_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg   <= prod_next;
            tmin3_reg  <= tmin2_reg;
            tmax3_reg  <= tmax2_reg;
            degen3_reg <= degen2_reg;
        end
    end

    // ---- stage 4: sums
    logic signed [SW-1:0] det_next, tn_next, gn_next, bn_next;
    logic signed [SW-1:0] det_reg, tn_reg, gn_reg, bn_reg;
    logic signed [T_W-1:0] tmin4_reg, tmax4_reg;
    logic degen4_reg, v4_reg;

    always_comb begin
        det_next = prod_reg[0] + prod_reg[1] + prod_reg[2];
        tn_next  = -(prod_reg[3] + prod_reg[4] + prod_reg[5]);
        gn_next  = prod_reg[6] + prod_reg[7] + prod_reg[8];
        bn_next  = prod_reg[9] + prod_reg[10] + prod_reg[11];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            det_reg    <= det_next;
            tn_reg     <= tn_next;
            gn_reg     <= gn_next;
            bn_reg     <= bn_next;
            tmin4_reg  <= tmin3_reg;
            tmax4_reg  <= tmax3_reg;
            degen4_reg <= degen3_reg;
        end
    end

    // ---- stage 5: make the determinant positive, scale t numerator
    logic signed [SW-1:0] det5_next, tn5, gn5_next, bn5_next;
    logic signed [TW-1:0] ts_next;
    logic bad_next;
    logic signed [SW-1:0] det5_reg, gn5_reg, bn5_reg;
    logic signed [TW-1:0] ts_reg;
    logic signed [T_W-1:0] tmin5_reg, tmax5_reg;
    logic bad5_reg, v5_reg;

    always_comb begin
        if (det_reg[SW-1]) begin
            det5_next = -det_reg;
            tn5       = -tn_reg;
            gn5_next  = -gn_reg;
            bn5_next  = -bn_reg;
        end else begin
            det5_next = det_reg;
            tn5       = tn_reg;
            gn5_next  = gn_reg;
            bn5_next  = bn_reg;
        end
        ts_next  = {tn5, {T_FRAC{1'b0}}};
        bad_next = degen4_reg || (det_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            det5_reg  <= det5_next;
            gn5_reg   <= gn5_next;
            bn5_reg   <= bn5_next;
            ts_reg    <= ts_next;
            tmin5_reg <= tmin4_reg;
            tmax5_reg <= tmax4_reg;
            bad5_reg  <= bad_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_bad   = bad5_reg;
    assign det_o     = det5_reg;
    assign ts_o      = ts_reg;
    assign gn_o      = gn5_reg;
    assign bn_o      = bn5_reg;
    assign tmin_o    = tmin5_reg;
    assign tmax_o    = tmax5_reg;

endmodule

### design/rti_range.sv
// rti_range: two stages of interval and barycentric tests.
// t_min*det and t_max*det are built from two half-width partial products. Uses rti_pkg.
module rti_range #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic                             in_bad,
    input  logic signed [3*COORD_WIDTH+5:0]  det_i,
    input  logic signed [3*COORD_WIDTH+21:0] ts_i,
    input  logic signed [3*COORD_WIDTH+5:0]  gn_i,
    input  logic signed [3*COORD_WIDTH+5:0]  bn_i,
    input  logic signed [rti_pkg::T_W-1:0]   tmin_i,
    input  logic signed [rti_pkg::T_W-1:0]   tmax_i,
    output rti_pkg::item_ctl_t               ctl_o,
    output logic [3*COORD_WIDTH+21:0]        mag_o,
    output logic [3*COORD_WIDTH+5:0]         det_o
);
    import rti_pkg::*;

    localparam int SW  = 3 * COORD_WIDTH + 6;
    localparam int TW  = SW + T_FRAC;
    localparam int LW  = SW / 2;
    localparam int HW  = SW - LW;
    localparam int PLW = T_W + LW + 1;
    localparam int PHW = T_W + HW + 1;
    localparam int CW  = T_W + SW + 2;

    // ---- stage 6: partial products and barycentric bounds
    logic signed [PLW-1:0] plmin_next, plmax_next, plmin_reg, plmax_reg;
    logic signed [PHW-1:0] phmin_next, phmax_next, phmin_reg, phmax_reg;
    logic signed [SW:0]    bg_sum;
    logic                  bad_next, bad6_reg, v6_reg;
    logic signed [TW-1:0]  ts6_reg;
    logic [SW-1:0]         det6_reg;

    always_comb begin
        plmin_next = tmin_i * $signed({1'b0, det_i[LW-1:0]});
        plmax_next = tmax_i * $signed({1'b0, det_i[LW-1:0]});
        phmin_next = tmin_i * $signed({1'b0, det_i[SW-1:LW]});
        phmax_next = tmax_i * $signed({1'b0, det_i[SW-1:LW]});
        bg_sum     = bn_i + gn_i;
        // gamma in [0,1], beta in [0,1-gamma]
        bad_next   = in_bad || gn_i[SW-1] || (det_i < gn_i) || bn_i[SW-1] || (det_i < bg_sum);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            plmin_reg <= plmin_next;
            plmax_reg <= plmax_next;
            phmin_reg <= phmin_next;
            phmax_reg <= phmax_next;
            bad6_reg  <= bad_next;
            ts6_reg   <= ts_i;
            det6_reg  <= det_i;
        end
    end

    // ---- stage 7: combine and compare against the scaled t numerator
    logic signed [CW-1:0] tlo, thi, tsx;
    logic [TW-1:0]        mag_next;
    item_ctl_t            ctl_next, ctl_reg;
    logic [TW-1:0]        mag_reg;
    logic [SW-1:0]        det7_reg;

    always_comb begin
        tlo = (CW'(phmin_reg) <<< LW) + CW'(plmin_reg);
        thi = (CW'(phmax_reg) <<< LW) + CW'(plmax_reg);
        tsx = CW'(ts6_reg);
        mag_next = ts6_reg[TW-1] ? TW'(-ts6_reg) : TW'(ts6_reg);
        ctl_next.valid = v6_reg;
        ctl_next.keep  = !bad6_reg && (tsx >= tlo) && (tsx <= thi);
        ctl_next.neg   = ts6_reg[TW-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.valid <= 1'b0;
        end else if (en) begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg  <= mag_next;
            det7_reg <= det6_reg;
        end
    end

    assign ctl_o = ctl_reg;
    assign mag_o = mag_reg;
    assign det_o = det7_reg;

`ifndef SYNTHESIS
    // a zero determinant must never survive as a hit
    a_keep_nonzero_det: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_reg.valid && ctl_reg.keep |-> det7_reg != '0)
        else $error("hit with zero determinant");
`endif

endmodule

### design/rti_div.sv
// rti_div: pipelined restoring divider, DIV_BPS quotient bits per stage,
// computes |t numerator| / det to 32 quotient bits. Uses rti_pkg.
module rti_div #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  rti_pkg::item_ctl_t          ctl_i,
    input  logic [3*COORD_WIDTH+21:0]   mag_i,
    input  logic [3*COORD_WIDTH+5:0]    det_i,
    output rti_pkg::item_ctl_t          ctl_o,
    output logic [rti_pkg::QUOT_BITS-1:0] quo_o
);
    import rti_pkg::*;

    localparam int SW  = 3 * COORD_WIDTH + 6;
    localparam int TW  = SW + T_FRAC;
    localparam int QB  = QUOT_BITS;
    localparam int NST = QB / DIV_BPS;

    item_ctl_t     ctl_reg [NST];
    logic [SW-1:0] rem_reg [NST];
    logic [SW-1:0] den_reg [NST];
    logic [QB-1:0] num_reg [NST];
    logic [QB-1:0] quo_reg [NST];

    for (genvar s = 0; s < NST; s++) begin : g_stage
        item_ctl_t     ctl_src;
        logic [SW-1:0] rem_src, den_src;
        logic [QB-1:0] num_src, quo_src;
        logic [SW-1:0] rem_next;
        logic [QB-1:0] num_next, quo_next;
        logic [SW:0]   trial;
        logic          ge;

        if (s == 0) begin : g_first
            // remainder starts with the numerator bits above the quotient
            assign ctl_src = ctl_i;
            assign rem_src = SW'(mag_i[TW-1:QB]);
            assign den_src = det_i;
            assign num_src = mag_i[QB-1:0];
            assign quo_src = '0;
        end else begin : g_rest
            assign ctl_src = ctl_reg[s-1];
            assign rem_src = rem_reg[s-1];
            assign den_src = den_reg[s-1];
            assign num_src = num_reg[s-1];
            assign quo_src = quo_reg[s-1];
        end

        // shift in DIV_BPS numerator bits one at a time, subtracting when the divisor fits
        always_comb begin
            rem_next = rem_src;
            num_next = num_src;
            quo_next = quo_src;
            trial    = '0;
            ge       = 1'b0;
            for (int b = 0; b < DIV_BPS; b++) begin
                trial    = {rem_next, num_next[QB-1]};
                ge       = trial >= {1'b0, den_src};
                rem_next = ge ? SW'(trial - {1'b0, den_src}) : trial[SW-1:0];
                num_next = {num_next[QB-2:0], 1'b0};
                quo_next = {quo_next[QB-2:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[s].valid <= 1'b0;
            end else if (en) begin
                ctl_reg[s] <= ctl_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s] <= rem_next;
                den_reg[s] <= den_src;
                num_reg[s] <= num_next;
                quo_reg[s] <= quo_next;
            end
        end
    end

    assign ctl_o = ctl_reg[NST-1];
    assign quo_o = quo_reg[NST-1];

`ifndef SYNTHESIS
    // for a hit the quotient fits, so the final remainder is below the divisor
    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_reg[NST-1].valid && ctl_reg[NST-1].keep |-> rem_reg[NST-1] < den_reg[NST-1])
        else $error("divider remainder not below divisor on a hit");
`endif

endmodule

### design/ray_triangle_intersect.sv
// ray_triangle_intersect: top level, pipelined ray/triangle test by Cramer's rule.
// Depends on rti_pkg, rti_geom, rti_range and rti_div.
//
//  port group   dir   word contents (low bit first)
//  s_*          in    origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_min, t_max
//  m_*          out   tdata: distance; tuser: hit
//  cfg_*        in    index 0..2 = vertex_a, vertex_b, vertex_c (x,y,z from low bits)
//
// Pipeline: 5 geometry + 2 range + 16 divider stages + 1 output register.
// One ray per cycle unless the output word is held; the 2-bit-per-stage divider pipeline sets the depth.
// aresetn is synchronous; it clears all valid bits and the vertex registers.
// The whole pipeline holds while the output word waits; s_tready drops then.
module ray_triangle_intersect #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_min, t_max, zero pad
    input  logic [((6*COORD_WIDTH+64+7)/8)*8-1:0] s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // distance
    output logic [31:0]                           m_tdata,
    // hit
    output logic [0:0]                            m_tuser,
    input  logic                                  cfg_wr_en,
    input  logic [rti_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [rti_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import rti_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int VW = 3 * W;
    localparam int SW = VW + 6;
    localparam int TW = SW + T_FRAC;

    // ---- vertex registers
    logic [VW-1:0]            vert_a_reg, vert_b_reg, vert_c_reg;
    logic [VW+CFG_DATA_W-1:0] cfg_wide;

    assign cfg_wide = {{VW{1'b0}}, cfg_data};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vert_a_reg <= '0;
            vert_b_reg <= '0;
            vert_c_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_VERTEX_A: vert_a_reg <= cfg_wide[VW-1:0];
                REG_VERTEX_B: vert_b_reg <= cfg_wide[VW-1:0];
                REG_VERTEX_C: vert_c_reg <= cfg_wide[VW-1:0];
                default: ;
            endcase
        end
    end

    // ---- global advance: move when the output word is empty or taken
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // ---- front end
    logic                  g_valid, g_bad;
    logic signed [SW-1:0]  g_det, g_gn, g_bn;
    logic signed [TW-1:0]  g_ts;
    logic signed [T_W-1:0] g_tmin, g_tmax;

    rti_geom #(.COORD_WIDTH(W)) u_geom (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid && s_tready),
        .vert_a   (vert_a_reg),
        .vert_b   (vert_b_reg),
        .vert_c   (vert_c_reg),
        .org      (s_tdata[VW-1:0]),
        .dir      (s_tdata[2*VW-1:VW]),
        .t_min    ($signed(s_tdata[2*VW +: T_W])),
        .t_max    ($signed(s_tdata[2*VW+T_W +: T_W])),
        .out_valid(g_valid),
        .out_bad  (g_bad),
        .det_o    (g_det),
        .ts_o     (g_ts),
        .gn_o     (g_gn),
        .bn_o     (g_bn),
        .tmin_o   (g_tmin),
        .tmax_o   (g_tmax)
    );

    // ---- interval and barycentric tests
    item_ctl_t     r_ctl;
    logic [TW-1:0] r_mag;
    logic [SW-1:0] r_det;

    rti_range #(.COORD_WIDTH(W)) u_range (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_valid(g_valid),
        .in_bad  (g_bad),
        .det_i   (g_det),
        .ts_i    (g_ts),
        .gn_i    (g_gn),
        .bn_i    (g_bn),
        .tmin_i  (g_tmin),
        .tmax_i  (g_tmax),
        .ctl_o   (r_ctl),
        .mag_o   (r_mag),
        .det_o   (r_det)
    );

    // ---- divider
    item_ctl_t            d_ctl;
    logic [QUOT_BITS-1:0] d_quo;

    rti_div #(.COORD_WIDTH(W)) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .en     (en),
        .ctl_i  (r_ctl),
        .mag_i  (r_mag),
        .det_i  (r_det),
        .ctl_o  (d_ctl),
        .quo_o  (d_quo)
    );

    // ---- output register
    logic        m_tvalid_reg, m_tuser_reg;
    logic [31:0] m_tdata_reg, dist_next;

    always_comb begin
        if (!d_ctl.keep) begin
            dist_next = '0;
        end else if (d_ctl.neg) begin
            dist_next = -d_quo[31:0];
        end else begin
            dist_next = d_quo[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= d_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= dist_next;
            m_tuser_reg <= d_ctl.keep;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

`ifndef SYNTHESIS
    // a miss always reports distance zero
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("miss with nonzero distance");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output word valid right after reset");

    // a vertex_a write lands in exactly the addressed register
    a_cfg_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en && cfg_index == REG_VERTEX_A |=> vert_a_reg == $past(cfg_wide[VW-1:0])
            && $stable(vert_b_reg) && $stable(vert_c_reg))
        else $error("vertex_a write misrouted");
`endif

endmodule
